// File: sv/dbs_pkg.sv
// ----------------------------------------------------------------------------
// dbs_pkg
// Types and codes shared by the deque/bag store and its checker.
// ----------------------------------------------------------------------------
package dbs_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_CONTAINS   = 3'd4,
        ACT_REMOVE     = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_FRONT,
        S_BACK,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
    } req_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [4:0]         count;
        logic               is_empty;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
    } rsp_word_t;

endpackage

// File: sv/dbs_ram.sv
// ----------------------------------------------------------------------------
// dbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dbs_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/deque_bag_store.sv
// ----------------------------------------------------------------------------
// deque_bag_store
// Bounded double-ended queue with value search and removal, circular store.
// ----------------------------------------------------------------------------
// Usage:
//   req (action, value) is taken on req_valid & req_ready; exactly one rsp
//   word comes back for each req word, in order, on rsp_valid/rsp_ready.
//   req_ready is high only while the sequencer is idle: one word at a time.
//   Entries live in a single RAM with one write and one registered read
//   port; every step goes through that port.
//   Each accepted word, whatever its code, passes the EXEC, FRONT, BACK and
//   FIN states; contains adds a SCAN step for each entry compared up to and
//   including the match (every entry on a miss), and in a remove the SCAN and
//   SHIFT steps together visit each entry once. Searches of an empty store
//   skip SCAN. The next req word can be taken in the same cycle that
//   rsp_valid rises, and never before the last word has been through FIN.
//   The last cycle loads the rsp register; if the previous rsp word is still
//   unaccepted the sequencer holds there until the receiver takes it, so a
//   stalled receiver blocks new req words but loses nothing.
//   Reset empties the store (head and count cleared); RAM contents are not
//   cleared and no live entry is ever read before it is written.
// ----------------------------------------------------------------------------
module deque_bag_store #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  dbs_pkg::req_word_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dbs_pkg::rsp_word_t  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    dbs_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [2:0]       act_reg, act_next;
    logic [SW-1:0]    val_reg, val_next;
    logic [1:0]       status_reg, status_next;
    logic             found_reg, found_next;
    logic [SW-1:0]    front_reg, front_next;
    logic             rsp_valid_reg, rsp_valid_next;
    dbs_pkg::rsp_word_t rsp_reg, rsp_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [SW-1:0]    wr_data;
    logic [AW-1:0]    rd_addr;
    logic [SW-1:0]    rd_data;

    logic [CW:0]      k_p1, k_p2, cnt_m1;
    logic             is_match, rsp_free;
    logic [CW+4:0]    cnt_wide;
    logic [SW+31:0]   front_wide, back_wide;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW:0] k);
        logic [CW+1:0] s;
        s = {{(CW+2-AW){1'b0}}, h} + {1'b0, k};
        if (s >= (CW+2)'(DEPTH))
        begin
            s = s - (CW+2)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    dbs_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign k_p1     = {1'b0, k_reg} + (CW+1)'(1);
    assign k_p2     = {1'b0, k_reg} + (CW+1)'(2);
    assign cnt_m1   = (count_reg == '0) ? '0 : ({1'b0, count_reg} - (CW+1)'(1));
    assign is_match = (rd_data == val_reg);
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    assign req_ready = (state_reg == dbs_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dbs_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = dbs_pkg::S_EXEC;
                end
            end
            dbs_pkg::S_EXEC:
            begin
                state_next = dbs_pkg::S_FRONT;
                if ((act_reg == dbs_pkg::ACT_CONTAINS || act_reg == dbs_pkg::ACT_REMOVE)
                    && count_reg != '0)
                begin
                    state_next = dbs_pkg::S_SCAN;
                end
            end
            dbs_pkg::S_SCAN:
            begin
                if (is_match)
                begin
                    if (act_reg == dbs_pkg::ACT_REMOVE && k_p1 < {1'b0, count_reg})
                    begin
                        state_next = dbs_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = dbs_pkg::S_FRONT;
                    end
                end
                else if (k_p1 >= {1'b0, count_reg})
                begin
                    state_next = dbs_pkg::S_FRONT;
                end
            end
            dbs_pkg::S_SHIFT:
            begin
                if (k_p2 >= {1'b0, count_reg})
                begin
                    state_next = dbs_pkg::S_FRONT;
                end
            end
            dbs_pkg::S_FRONT: state_next = dbs_pkg::S_BACK;
            dbs_pkg::S_BACK:  state_next = dbs_pkg::S_FIN;
            dbs_pkg::S_FIN:
            begin
                if (rsp_free)
                begin
                    state_next = dbs_pkg::S_IDLE;
                end
            end
            default: state_next = dbs_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        front_next     = front_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        wr_data        = val_reg;
        rd_addr        = head_reg;
        cnt_wide       = {5'd0, count_reg};
        front_wide     = {32'd0, front_reg};
        back_wide      = {32'd0, rd_data};

        unique case (state_reg)
            dbs_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next    = req.action;
                    val_next    = req.value[SW-1:0];
                    status_next = dbs_pkg::ST_OK;
                    found_next  = 1'b0;
                end
            end
            dbs_pkg::S_EXEC:
            begin
                k_next = '0;
                case (dbs_pkg::action_t'(act_reg))
                    dbs_pkg::ACT_PUSH_FRONT:
                    begin
                        if (count_reg >= CW'(DEPTH))
                        begin
                            status_next = dbs_pkg::ST_FULL;
                        end
                        else
                        begin
                            head_next  = (head_reg == '0) ? AW'(DEPTH - 1)
                                                          : head_reg - AW'(1);
                            wr_en      = 1'b1;
                            wr_addr    = head_next;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    dbs_pkg::ACT_PUSH_BACK:
                    begin
                        if (count_reg >= CW'(DEPTH))
                        begin
                            status_next = dbs_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = slot_of(head_reg, {1'b0, count_reg});
                            count_next = count_reg + CW'(1);
                        end
                    end
                    dbs_pkg::ACT_POP_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = dbs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            head_next  = slot_of(head_reg, (CW+1)'(1));
                            count_next = count_reg - CW'(1);
                        end
                    end
                    dbs_pkg::ACT_POP_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = dbs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    dbs_pkg::ACT_CONTAINS, dbs_pkg::ACT_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = dbs_pkg::ST_EMPTY;
                        end
                        rd_addr = head_reg;
                    end
                    default:
                    begin
                        status_next = dbs_pkg::ST_OK;
                    end
                endcase
            end
            dbs_pkg::S_SCAN:
            begin
                // rd_data holds position k; fetch k+1 for the next compare or shift
                rd_addr = slot_of(head_reg, k_p1);
                if (is_match)
                begin
                    found_next  = 1'b1;
                    status_next = dbs_pkg::ST_OK;
                    if (act_reg == dbs_pkg::ACT_REMOVE && k_p1 >= {1'b0, count_reg})
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                else if (k_p1 >= {1'b0, count_reg})
                begin
                    status_next = dbs_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    k_next = k_p1[CW-1:0];
                end
            end
            dbs_pkg::S_SHIFT:
            begin
                // rd_data holds position k+1; move it down to k
                wr_en   = 1'b1;
                wr_addr = slot_of(head_reg, {1'b0, k_reg});
                wr_data = rd_data;
                rd_addr = slot_of(head_reg, k_p2);
                if (k_p2 >= {1'b0, count_reg})
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    k_next = k_p1[CW-1:0];
                end
            end
            dbs_pkg::S_FRONT:
            begin
                rd_addr = head_reg;
            end
            dbs_pkg::S_BACK:
            begin
                front_next = rd_data;
                rd_addr    = slot_of(head_reg, cnt_m1);
            end
            dbs_pkg::S_FIN:
            begin
                // keep the back entry on the read port while waiting
                rd_addr = slot_of(head_reg, cnt_m1);
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.found       = found_reg;
                    rsp_next.count       = cnt_wide[4:0];
                    rsp_next.is_empty    = (count_reg == '0);
                    rsp_next.front_value = (count_reg == '0) ? '0 : front_wide[31:0];
                    rsp_next.back_value  = (count_reg == '0) ? '0 : back_wide[31:0];
                end
            end
            default:
            begin
                rd_addr = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dbs_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        act_reg    <= act_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        front_reg  <= front_next;
        rsp_reg    <= rsp_next;
    end

endmodule

// File: sv/dbs_checker.sv
// ----------------------------------------------------------------------------
// dbs_checker
// Port-level checks on the deque/bag store, bound to deque_bag_store.
// ----------------------------------------------------------------------------
module dbs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input dbs_pkg::req_word_t req,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input dbs_pkg::rsp_word_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req accepted while busy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |-> rsp.front_value == 0 && rsp.back_value == 0)
        else $error("front/back not zero on empty store");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.status == dbs_pkg::ST_OK)
        else $error("found with error status");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == dbs_pkg::ST_FULL |-> !rsp.is_empty && !rsp.found)
        else $error("full status on empty store");

endmodule

bind deque_bag_store dbs_checker u_dbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
